// ===== rtl/core/ccs_pkg.sv =====
// Shared types and character constants of the comment stripper.
package ccs_pkg;

	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	// One queued job: either a single result, or a slash followed by ch.
	typedef struct packed {
		logic       two;
		logic [7:0] ch;
		logic       has;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== rtl/core/ccs_stream_ifs.sv =====
// Valid/ready stream interfaces for the text input and the stripped output.
interface ccs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface ccs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last_of_run;

	modport source (output valid, out_byte, has_byte, last_of_run, input ready);
	modport sink (input valid, out_byte, has_byte, last_of_run, output ready);
endinterface

// ===== rtl/core/ccs_front.sv =====
// Front end: accepts text beats, tracks the scan mode and queues result jobs.
module ccs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	ccs_in_if.sink                 in_ch,
	input  ccs_pkg::queue_status_t status,
	output logic                   push,
	output ccs_pkg::entry_t        entry
);

	typedef enum logic [6:0] {
		M_NORMAL     = 7'b0000001,
		M_SLASH      = 7'b0000010,
		M_LINE       = 7'b0000100,
		M_BLOCK      = 7'b0001000,
		M_BLOCK_STAR = 7'b0010000,
		M_STRING     = 7'b0100000,
		M_CHAR       = 7'b1000000
	} mode_t;

	mode_t      mode_q, mode_d, mode_c;
	logic       esc_q, esc_d, esc_c;
	logic       emit_c, two_c, accept;
	logic [7:0] b;

	assign b           = in_ch.text_byte;
	assign in_ch.ready = !status.full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		mode_c = mode_q;
		esc_c  = esc_q;
		emit_c = 1'b0;
		two_c  = 1'b0;
		case (mode_q)
			M_SLASH: begin
				if (b == ccs_pkg::CH_SLASH) begin
					mode_c = M_LINE;
				end else if (b == ccs_pkg::CH_STAR) begin
					mode_c = M_BLOCK;
				end else begin
					emit_c = 1'b1;
					two_c  = 1'b1;
					if (b == ccs_pkg::CH_DQUOTE) begin
						mode_c = M_STRING;
						esc_c  = 1'b0;
					end else if (b == ccs_pkg::CH_SQUOTE) begin
						mode_c = M_CHAR;
						esc_c  = 1'b0;
					end else begin
						mode_c = M_NORMAL;
					end
				end
			end
			M_LINE: begin
				if (b == ccs_pkg::CH_NEWLINE) mode_c = M_NORMAL;
			end
			M_BLOCK: begin
				if (b == ccs_pkg::CH_STAR) mode_c = M_BLOCK_STAR;
			end
			M_BLOCK_STAR: begin
				if (b == ccs_pkg::CH_SLASH) mode_c = M_NORMAL;
				else if (b != ccs_pkg::CH_STAR) mode_c = M_BLOCK;
			end
			M_STRING, M_CHAR: begin
				emit_c = 1'b1;
				if (esc_q) begin
					esc_c = 1'b0;
				end else if (b == ccs_pkg::CH_BACKSLASH) begin
					esc_c = 1'b1;
				end else if ((mode_q == M_STRING && b == ccs_pkg::CH_DQUOTE) ||
						(mode_q == M_CHAR && b == ccs_pkg::CH_SQUOTE)) begin
					mode_c = M_NORMAL;
				end
			end
			default: begin
				if (b == ccs_pkg::CH_SLASH) begin
					mode_c = M_SLASH;
				end else begin
					emit_c = 1'b1;
					if (b == ccs_pkg::CH_DQUOTE) begin
						mode_c = M_STRING;
						esc_c  = 1'b0;
					end else if (b == ccs_pkg::CH_SQUOTE) begin
						mode_c = M_CHAR;
						esc_c  = 1'b0;
					end else begin
						mode_c = M_NORMAL;
					end
				end
			end
		endcase
	end

	always_comb begin
		entry.two  = two_c;
		entry.ch   = b;
		entry.has  = emit_c;
		entry.last = in_ch.end_of_text;
		push       = accept && emit_c;
		mode_d     = mode_c;
		esc_d      = esc_c;
		if (in_ch.end_of_text) begin
			push = accept;
			if (mode_c == M_SLASH) begin
				// flush the held slash as the final result
				entry.ch  = ccs_pkg::CH_SLASH;
				entry.has = 1'b1;
			end else if (!emit_c) begin
				entry.ch = 8'h00;
			end
			mode_d = M_NORMAL;
			esc_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			esc_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
		end
	end

endmodule

// ===== rtl/core/ccs_queue.sv =====
// Short job queue between the front and back ends.
module ccs_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ccs_pkg::entry_t        wr_entry,
	input  logic                   pop,
	output ccs_pkg::entry_t        head,
	output ccs_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ccs_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/ccs_back.sv =====
// Back end: expands queued jobs into output beats through an output register.
module ccs_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ccs_pkg::entry_t        head,
	input  ccs_pkg::queue_status_t status,
	output logic                   pop,
	ccs_out_if.source              out_ch
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_q, last_q;
	logic       pend_q;
	logic [7:0] pend_ch_q;
	logic       pend_last_q;
	logic       advance;

	assign advance = !out_valid_q || out_ch.ready;
	assign pop     = advance && !pend_q && !status.empty;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.has_byte    = has_q;
	assign out_ch.last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (advance) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= !status.empty;
				pend_q      <= !status.empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_q) begin
				out_byte_q <= pend_ch_q;
				has_q      <= 1'b1;
				last_q     <= pend_last_q;
			end else if (head.two) begin
				// held slash goes first, the byte after it follows
				out_byte_q  <= ccs_pkg::CH_SLASH;
				has_q       <= 1'b1;
				last_q      <= 1'b0;
				pend_ch_q   <= head.ch;
				pend_last_q <= head.last;
			end else begin
				out_byte_q <= head.ch;
				has_q      <= head.has;
				last_q     <= head.last;
			end
		end
	end

endmodule

// ===== rtl/core/c_comment_stripper_core.sv =====
// Top level of the C/C++ comment stripper: front end, job queue and back end.
//
// Usage: source text enters on in_ch one byte per beat (text_byte), with
// end_of_text set on the final byte of a text. Stripped text leaves on out_ch,
// one byte per beat (out_byte, has_byte = 1); last_of_run marks the final beat
// of a text, which is a bare end marker (has_byte = 0) when the final byte
// yields nothing else. A following byte starts a new text.
// Throughput: one input beat per cycle while in_ch.ready is high. Each byte
// gives zero, one or two output beats; a slash released together with the byte
// after it takes two output beats, and the job queue soaks these up until full.
// Path: an input beat is written into the queue, then into the output
// register, from which it is offered on out_ch.
// Stall: when out_ch.ready is low the output register holds its beat, the
// queue fills, and in_ch.ready drops once QUEUE_DEPTH jobs are waiting.
// Reset (arst_n low): the scan returns to plain text, the queue empties and
// no output beat is offered.
module c_comment_stripper_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	ccs_in_if.sink    in_ch,
	ccs_out_if.source out_ch
);

	ccs_pkg::entry_t        wr_entry, head;
	ccs_pkg::queue_status_t status;
	logic                   push, pop;

	// classify each byte and queue its results
	ccs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.status (status),
		.push   (push),
		.entry  (wr_entry)
	);

	// decouple scanning from the output handshake
	ccs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	// drive output beats, splitting two-byte jobs
	ccs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (status),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
